// File: hdl/fpmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpmt_pkg
// Shared widths, defaults and operation codes of the prefix-max tree.
// ----------------------------------------------------------------------------
package fpmt_pkg;

  localparam int POS_W       = 11;
  localparam int SIZE_W      = 11;
  localparam int IDX_W       = POS_W + 1;
  localparam int SIZE_MAX    = (2 ** SIZE_W) - 1;
  localparam int DEPTH_DEF   = 1024;
  localparam int VALUE_W_DEF = 48;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [IDX_W-1:0] idx_t;

  localparam logic FUNC_RAISE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

endpackage

// File: hdl/fpmt_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpmt_ifs
// Valid/ready channels carrying command words and result words.
// ----------------------------------------------------------------------------
interface fpmt_in_if
  import fpmt_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_W_DEF
);
  logic                   valid;
  logic                   ready;
  logic                   func;
  pos_t                   position;
  logic [VALUE_WIDTH-1:0] new_value;

  modport source (output valid, output func, output position, output new_value,
                  input ready);
  modport sink (input valid, input func, input position, input new_value,
                output ready);
endinterface

interface fpmt_out_if
  import fpmt_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_W_DEF
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] prefix_max;

  modport source (output valid, output prefix_max, input ready);
  modport sink (input valid, input prefix_max, output ready);
endinterface

// File: hdl/fpmt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpmt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fpmt_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/fenwick_prefix_max_tree_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fenwick_prefix_max_tree_core
// Binary indexed tree of running maxima held in one node RAM.
// ----------------------------------------------------------------------------
// After reset the block sweeps the node RAM to zero, one entry a cycle, and
// takes no command word until the sweep ends (configuration writes are taken).
// Each command then visits one tree node per cycle through the node RAM's
// single read and single write port: a raise at position p is accepted and
// then visits each covering node on the upward walk; a query is accepted,
// visits each node on the downward walk and then loads the result register.
// With 1024 positions a walk visits at most 11 nodes. Raises at position
// zero or above the size in use, and queries at position zero, finish in
// the accept cycle; such a query then goes straight to loading the result
// register. A new command is taken while a result word waits; a query that
// finishes while the previous result word is still unread holds in its last
// cycle until that word is taken.
module fenwick_prefix_max_tree_core
  import fpmt_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_W_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  size_t             cfg_data,
  fpmt_in_if.sink           in_ch,
  fpmt_out_if.source        out_ch
);

  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int DEPTH_CLIP = (DEPTH > SIZE_MAX) ? SIZE_MAX : DEPTH;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [ADDR_W-1:0]      clr_addr_r, clr_addr_nxt;
  size_t                  size_r, size_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [VALUE_WIDTH-1:0] out_data_r, out_data_nxt;
  idx_t                   idx_r, idx_nxt;
  idx_t                   lim_r, lim_nxt;
  logic                   is_query_r, is_query_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic [VALUE_WIDTH-1:0] best_r, best_nxt;

  idx_t                   lim_cur, in_pos, q_start, start_idx, rd_slot;
  idx_t                   lowbit, up_nxt, dn_nxt, walk_nxt;
  logic                   start_ok, walk_more, accept;
  logic                   wr_en, rd_en;
  logic [ADDR_W-1:0]      wr_addr, rd_addr;
  logic [VALUE_WIDTH-1:0] wr_data, node;

  assign lim_cur = (size_r > SIZE_W'(DEPTH_CLIP)) ? IDX_W'(DEPTH_CLIP) : {1'b0, size_r};
  assign in_pos  = {1'b0, in_ch.position};
  assign q_start = (in_pos > lim_cur) ? lim_cur : in_pos;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  assign start_idx = (in_ch.func == FUNC_QUERY) ? q_start : in_pos;
  assign start_ok  = (in_ch.func == FUNC_QUERY) ? (q_start != '0)
                                                : ((in_pos != '0) && (in_pos <= lim_cur));

  assign lowbit    = idx_r & (~idx_r + IDX_W'(1));
  assign up_nxt    = idx_r + lowbit;
  assign dn_nxt    = idx_r & (idx_r - IDX_W'(1));
  assign walk_nxt  = is_query_r ? dn_nxt : up_nxt;
  assign walk_more = is_query_r ? (dn_nxt != '0) : (up_nxt <= lim_r);

  assign rd_en   = (accept && start_ok) || ((state_r == ST_WALK) && walk_more);
  assign rd_slot = (accept ? start_idx : walk_nxt) - IDX_W'(1);
  assign rd_addr = ADDR_W'(rd_slot);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr_r;
    wr_data = '0;
    case (state_r)
      ST_CLEAR: begin
        wr_en = 1'b1;
      end
      ST_WALK: begin
        if (!is_query_r && (node < val_r)) begin
          wr_en   = 1'b1;
          wr_addr = ADDR_W'(idx_r - IDX_W'(1));
          wr_data = val_r;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  fpmt_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_nodes (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (node)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    size_nxt      = cfg_we ? cfg_data : size_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    idx_nxt       = idx_r;
    lim_nxt       = lim_r;
    is_query_nxt  = is_query_r;
    val_nxt       = val_r;
    best_nxt      = best_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          is_query_nxt = in_ch.func;
          val_nxt      = in_ch.new_value;
          lim_nxt      = lim_cur;
          idx_nxt      = start_idx;
          best_nxt     = '0;
          if (start_ok) begin
            state_nxt = ST_WALK;
          end else if (in_ch.func == FUNC_QUERY) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_WALK: begin
        if (is_query_r && (node > best_r)) begin
          best_nxt = node;
        end
        if (walk_more) begin
          idx_nxt = walk_nxt;
        end else begin
          state_nxt = is_query_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = best_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      size_r      <= SIZE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      size_r      <= size_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    idx_r      <= idx_nxt;
    lim_r      <= lim_nxt;
    is_query_r <= is_query_nxt;
    val_r      <= val_nxt;
    best_r     <= best_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.prefix_max = out_data_r;

`ifndef SYNTH
  a_no_cmd_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_ch.ready)
    else $error("command word taken during clearing pass");

  a_raise_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_WALK) && !is_query_r) |-> ((idx_r != '0) && (idx_r <= lim_r)))
    else $error("raise walk left the tree range");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result word without finished query");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("node read and write hit the same entry");
`endif

endmodule
